// ===== sv/bfsp_pkg.sv =====
package bfsp_pkg;

	localparam int MAX_VERTICES = 64;
	localparam int MAX_EDGES    = 1024;

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int EW  = $clog2(MAX_EDGES);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int WW  = 16;
	localparam int DW  = 32;

	typedef logic [1:0] op_t;
	localparam op_t OP_CLEAR = 2'd0;
	localparam op_t OP_ADD   = 2'd1;
	localparam op_t OP_RUN   = 2'd2;

	typedef struct packed {
		logic                 clear;
		logic                 add;
		logic [VW-1:0]        tail_v;
		logic [VW-1:0]        head_v;
		logic signed [WW-1:0] weight;
	} edge_add_t;

	typedef struct packed {
		logic [EW-1:0] first_e;
		logic [EW-1:0] last_e;
	} list_rsp_t;

	typedef struct packed {
		logic [VW-1:0]        head_v;
		logic signed [WW-1:0] weight;
		logic [EW-1:0]        next_e;
	} edge_rsp_t;

	typedef struct packed {
		logic [VW-1:0]        pred;
		logic signed [DW-1:0] path_len;
	} vrec_t;

	// Signed add that clamps at the 32-bit limits.
	function automatic logic signed [DW-1:0] sat_add(input logic signed [DW-1:0] a,
			input logic signed [WW-1:0] b);
		logic signed [DW:0] s;
		s = {a[DW-1], a} + (DW+1)'(b);
		if (s[DW] != s[DW-1]) begin
			sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			sat_add = s[DW-1:0];
		end
	endfunction

endpackage

// ===== sv/bfsp_edge_list.sv =====
module bfsp_edge_list (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bfsp_pkg::edge_add_t                 req,
	input  logic                                list_rd,
	input  logic [bfsp_pkg::VW-1:0]             list_addr,
	input  logic                                edge_rd,
	input  logic [bfsp_pkg::EW-1:0]             edge_addr,
	output logic [bfsp_pkg::MAX_VERTICES-1:0]   list_valid,
	output bfsp_pkg::list_rsp_t                 list_rsp,
	output bfsp_pkg::edge_rsp_t                 edge_rsp,
	output logic                                dropped
);
	import bfsp_pkg::*;

	typedef struct packed {
		logic [VW-1:0]        head_v;
		logic signed [WW-1:0] weight;
	} edge_ent_t;

	// Edges are kept in load order and chained per tail vertex.
	edge_ent_t  edge_mem [MAX_EDGES];
	logic [EW-1:0] next_mem [MAX_EDGES];
	list_rsp_t  list_mem [MAX_VERTICES];

	logic [ECW-1:0]          total_q;
	logic [MAX_VERTICES-1:0] valid_q;
	logic                    dropped_q;
	logic                    link_q;
	logic [VW-1:0]           link_v_q;
	logic [EW-1:0]           link_e_q;
	edge_ent_t               edge_rd_q;
	logic [EW-1:0]           next_rd_q;
	list_rsp_t               list_rd_q;
	logic                    full;
	logic                    take;

	assign full = (total_q == ECW'(MAX_EDGES));
	assign take = req.add && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q   <= '0;
			valid_q   <= '0;
			dropped_q <= 1'b0;
			link_q    <= 1'b0;
		end else begin
			link_q <= take;
			if (req.clear) begin
				total_q   <= '0;
				valid_q   <= '0;
				dropped_q <= 1'b0;
			end else if (req.add) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					total_q <= total_q + ECW'(1);
				end
			end
			if (link_q) begin
				valid_q[link_v_q] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		link_v_q <= req.tail_v;
		link_e_q <= total_q[EW-1:0];
	end

	always_ff @(posedge clk) begin
		if (take) begin
			edge_mem[total_q[EW-1:0]] <= '{head_v: req.head_v, weight: req.weight};
		end
		if (edge_rd) begin
			edge_rd_q <= edge_mem[edge_addr];
		end
	end

	// After an add is taken, its registered link step hooks the new edge behind the old tail of its list.
	always_ff @(posedge clk) begin
		if (link_q && valid_q[link_v_q]) begin
			next_mem[list_rd_q.last_e] <= link_e_q;
		end
		if (edge_rd) begin
			next_rd_q <= next_mem[edge_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (link_q) begin
			if (valid_q[link_v_q]) begin
				list_mem[link_v_q] <= '{first_e: list_rd_q.first_e, last_e: link_e_q};
			end else begin
				list_mem[link_v_q] <= '{first_e: link_e_q, last_e: link_e_q};
			end
		end
		if (req.add || list_rd) begin
			list_rd_q <= list_mem[req.add ? req.tail_v : list_addr];
		end
	end

	assign list_valid = valid_q;
	assign list_rsp   = list_rd_q;
	assign edge_rsp   = '{head_v: edge_rd_q.head_v, weight: edge_rd_q.weight,
		next_e: next_rd_q};
	assign dropped    = dropped_q;

endmodule

// ===== sv/bellman_ford_shortest_paths.sv =====
// Clear leaves busy low, and an add edge holds busy high for its link step.
// After a run request busy stays high through the relaxation passes and then through
// the output of one result per vertex in use; each edge is read in S_EDGE and relaxed
// in S_RELAX, because its head distance is read and written back.
// Results come out one per cycle at the end of the run, and the receiver cannot stall them.
// Reset empties the edge list, clears the dropped flag and sets vertex_count to 64.
module bellman_ford_shortest_paths (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wen,
	input  logic [bfsp_pkg::NW-1:0]           cfg_wdata,
	input  logic                              start,
	output logic                              busy,
	input  logic [1:0]                        operation,
	input  logic [bfsp_pkg::VW-1:0]           from_vertex,
	input  logic [bfsp_pkg::VW-1:0]           to_vertex,
	input  logic signed [bfsp_pkg::WW-1:0]    edge_weight,
	input  logic [bfsp_pkg::VW-1:0]           source_vertex,
	output logic                              result_valid,
	output logic [bfsp_pkg::VW-1:0]           vertex_index,
	output logic signed [bfsp_pkg::DW-1:0]    distance,
	output logic                              reachable,
	output logic [bfsp_pkg::VW-1:0]           predecessor,
	output logic                              edges_dropped,
	output logic                              last
);
	import bfsp_pkg::*;

	// Controller states. A pass visits tails in ascending order; for each reachable
	// tail with edges, the tail's chain is walked in load order, through S_EDGE and S_RELAX an edge.
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ADD   = 3'd1;
	localparam logic [2:0] S_VTX   = 3'd2;
	localparam logic [2:0] S_LIST  = 3'd3;
	localparam logic [2:0] S_EDGE  = 3'd4;
	localparam logic [2:0] S_RELAX = 3'd5;
	localparam logic [2:0] S_OUT   = 3'd6;
	localparam logic [2:0] S_DRAIN = 3'd7;

	logic [2:0]              state_q;
	logic [NW-1:0]           n_q;
	logic [NW-1:0]           t_q;
	logic [VW-1:0]           pass_q;
	logic                    changed_q;
	logic [VW-1:0]           v_q;
	logic [MAX_VERTICES-1:0] reach_q;

	// Per-edge working registers.
	logic [EW-1:0]           e_q;
	logic [EW-1:0]           tail_q;
	logic [EW-1:0]           next_q;
	logic [VW-1:0]           h_q;
	logic signed [WW-1:0]    w_q;
	logic signed [DW-1:0]    cur_dist_q;

	// Result stage.
	logic                    valid_s1;
	logic                    last_s1;
	logic [VW-1:0]           v_s1;

	// Vertex memory: distance and predecessor of each vertex.
	vrec_t                   vstore [MAX_VERTICES];
	vrec_t                   vrd_q;
	logic                    vs_we;
	logic [VW-1:0]           vs_waddr;
	vrec_t                   vs_wdata;
	logic                    vs_re;
	logic [VW-1:0]           vs_raddr;

	edge_add_t               add_req;
	logic                    list_rd;
	logic [VW-1:0]           list_addr;
	logic                    edge_rd;
	logic [EW-1:0]           edge_addr;
	logic [MAX_VERTICES-1:0] list_valid;
	list_rsp_t               list_rsp;
	edge_rsp_t               edge_rsp;
	logic                    dropped;

	logic                    accept;
	logic                    run_go;
	logic                    src_ok;
	logic signed [DW-1:0]    cand;
	logic                    head_ok;
	logic                    relax_hit;
	logic                    tail_live;
	logic                    out_last;
	logic                    more_passes;
	logic [NW-1:0]           cfg_clamped;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign run_go = accept && (operation == OP_RUN);
	assign src_ok = ({1'b0, source_vertex} < n_q);

	assign add_req = '{clear: accept && (operation == OP_CLEAR),
		add: accept && (operation == OP_ADD),
		tail_v: from_vertex, head_v: to_vertex, weight: edge_weight};

	// An edge whose head lies outside the vertices in use is skipped. An unreached head
	// always takes the candidate; otherwise only a strictly smaller distance does.
	assign cand      = sat_add(cur_dist_q, w_q);
	assign head_ok   = ({1'b0, h_q} < n_q);
	assign relax_hit = (state_q == S_RELAX) && head_ok &&
		(!reach_q[h_q] || (cand < vrd_q.path_len));
	assign tail_live = reach_q[t_q[VW-1:0]] && list_valid[t_q[VW-1:0]];
	assign out_last  = ((NW'(v_q) + NW'(1)) == n_q);
	// Pass p (from zero) is followed by another only if it changed something and
	// p + 2 < n, which keeps the total at n - 1 passes or fewer.
	assign more_passes = changed_q && ((NW'(pass_q) + NW'(2)) < n_q);

	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_clamped = NW'(1);
		end else if (cfg_wdata > NW'(MAX_VERTICES)) begin
			cfg_clamped = NW'(MAX_VERTICES);
		end else begin
			cfg_clamped = cfg_wdata;
		end
	end

	// Vertex memory port control.
	always_comb begin
		vs_we    = 1'b0;
		vs_waddr = source_vertex;
		vs_wdata = '{pred: '0, path_len: '0};
		if (run_go && src_ok) begin
			vs_we = 1'b1;
		end else if (relax_hit) begin
			vs_we    = 1'b1;
			vs_waddr = h_q;
			vs_wdata = '{pred: t_q[VW-1:0], path_len: cand};
		end
	end

	always_comb begin
		vs_re     = 1'b0;
		vs_raddr  = t_q[VW-1:0];
		list_rd   = 1'b0;
		list_addr = t_q[VW-1:0];
		edge_rd   = 1'b0;
		edge_addr = list_rsp.first_e;
		unique case (state_q)
			S_VTX: begin
				if (t_q != n_q && tail_live) begin
					vs_re   = 1'b1;
					list_rd = 1'b1;
				end
			end
			S_LIST: begin
				edge_rd = 1'b1;
			end
			S_EDGE: begin
				vs_re    = 1'b1;
				vs_raddr = edge_rsp.head_v;
				// Fetch the next edge of the chain while this one is relaxed.
				edge_rd   = (e_q != tail_q);
				edge_addr = edge_rsp.next_e;
			end
			S_OUT: begin
				vs_re    = 1'b1;
				vs_raddr = v_q;
			end
			S_IDLE, S_ADD, S_RELAX, S_DRAIN: begin
			end
		endcase
	end

	// A write in the relax cycle is always at least one edge ahead of the next read,
	// so the vertex memory needs no forwarding.
	always_ff @(posedge clk) begin
		if (vs_we) begin
			vstore[vs_waddr] <= vs_wdata;
		end
		if (vs_re) begin
			vrd_q <= vstore[vs_raddr];
		end
	end

	bfsp_edge_list u_edges (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (add_req),
		.list_rd    (list_rd),
		.list_addr  (list_addr),
		.edge_rd    (edge_rd),
		.edge_addr  (edge_addr),
		.list_valid (list_valid),
		.list_rsp   (list_rsp),
		.edge_rsp   (edge_rsp),
		.dropped    (dropped)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			n_q       <= NW'(MAX_VERTICES);
			t_q       <= '0;
			pass_q    <= '0;
			changed_q <= 1'b0;
			v_q       <= '0;
			reach_q   <= '0;
			valid_s1  <= 1'b0;
		end else begin
			valid_s1 <= (state_q == S_OUT);
			if (cfg_wen) begin
				n_q <= cfg_clamped;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept && operation == OP_ADD) begin
						state_q <= S_ADD;
					end else if (run_go) begin
						// Only the source starts out reached, and only if it is in use.
						reach_q   <= src_ok ? (MAX_VERTICES'(1) << source_vertex) : '0;
						t_q       <= '0;
						pass_q    <= '0;
						changed_q <= 1'b0;
						v_q       <= '0;
						state_q <= (src_ok && n_q > NW'(1)) ? S_VTX : S_OUT;
					end
				end
				S_ADD: begin
					state_q <= S_IDLE;
				end
				S_VTX: begin
					if (t_q == n_q) begin
						if (more_passes) begin
							pass_q    <= pass_q + VW'(1);
							t_q       <= '0;
							changed_q <= 1'b0;
						end else begin
							v_q     <= '0;
							state_q <= S_OUT;
						end
					end else if (tail_live) begin
						state_q <= S_LIST;
					end else begin
						t_q <= t_q + NW'(1);
					end
				end
				S_LIST: begin
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					state_q <= S_RELAX;
				end
				S_RELAX: begin
					if (relax_hit) begin
						reach_q[h_q] <= 1'b1;
						changed_q    <= 1'b1;
					end
					if (e_q == tail_q) begin
						t_q     <= t_q + NW'(1);
						state_q <= S_VTX;
					end else begin
						state_q <= S_EDGE;
					end
				end
				S_OUT: begin
					v_q <= v_q + VW'(1);
					if (out_last) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Edge walk payload. A self loop changes the tail's own distance in mid-list,
	// so the held tail distance follows that write.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_LIST: begin
				cur_dist_q <= vrd_q.path_len;
				tail_q     <= list_rsp.last_e;
				e_q        <= list_rsp.first_e;
			end
			S_EDGE: begin
				h_q    <= edge_rsp.head_v;
				w_q    <= edge_rsp.weight;
				next_q <= edge_rsp.next_e;
			end
			S_RELAX: begin
				if (relax_hit && ({1'b0, h_q} == t_q)) begin
					cur_dist_q <= cand;
				end
				e_q <= next_q;
			end
			S_IDLE, S_ADD, S_VTX, S_OUT, S_DRAIN: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == S_OUT) begin
			v_s1    <= v_q;
			last_s1 <= out_last;
		end
	end

	// Results: an unreached vertex shows zero distance and predecessor.
	assign result_valid  = valid_s1;
	assign vertex_index  = v_s1;
	assign reachable     = reach_q[v_s1];
	assign distance      = reachable ? vrd_q.path_len : '0;
	assign predecessor   = reachable ? vrd_q.pred : '0;
	assign edges_dropped = dropped;
	assign last          = last_s1;

	// Results appear only while a run holds the block busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe outside a run");

	// The results of a run come out back to back until the last one.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |=> result_valid)
		else $error("gap in the result sequence");

	// Nothing follows the last result of a run.
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid && !busy)
		else $error("result after the last one");

	// An add request holds the block for its link cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && operation == OP_ADD |=> busy && !result_valid)
		else $error("add request did not take its link cycle");

endmodule

// ===== verif/testbench.sv =====
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bfsp_pkg::*;

	// Operation code 3 has no meaning; the block accepts it and does nothing.
	localparam op_t OP_NONE = 2'd3;

	// An add request keeps the block busy for its link step after acceptance, so a short
	// settle is enough before a configuration write once all results have come.
	localparam int SETTLE_CYCLES = 4;
	// Quiet cycles after the last expected result, to catch any stray result.
	localparam int END_CYCLES = 200;
	// Hard limit on simulated time, in ns, at a clock period of 20 ns; it has to cover
	// the longest full-length runs of the test.
	localparam longint TIMEOUT_NS = 400_000_000;

	// One vertex result as the block should report it.
	typedef struct {
		logic [VW-1:0]        vertex;
		logic signed [DW-1:0] path_len;
		logic                 reached;
		logic [VW-1:0]        via;
		logic                 dropped;
		logic                 is_last;
	} vertex_result_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [NW-1:0]        cfg_wdata;
	logic                 start;
	logic                 busy;
	logic [1:0]           operation;
	logic [VW-1:0]        from_vertex;
	logic [VW-1:0]        to_vertex;
	logic signed [WW-1:0] edge_weight;
	logic [VW-1:0]        source_vertex;
	logic                 result_valid;
	logic [VW-1:0]        vertex_index;
	logic signed [DW-1:0] distance;
	logic                 reachable;
	logic [VW-1:0]        predecessor;
	logic                 edges_dropped;
	logic                 last;

	bellman_ford_shortest_paths DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_wdata    (cfg_wdata),
		.start        (start),
		.busy         (busy),
		.operation    (operation),
		.from_vertex  (from_vertex),
		.to_vertex    (to_vertex),
		.edge_weight  (edge_weight),
		.source_vertex(source_vertex),
		.result_valid (result_valid),
		.vertex_index (vertex_index),
		.distance     (distance),
		.reachable    (reachable),
		.predecessor  (predecessor),
		.edges_dropped(edges_dropped),
		.last         (last)
	);

	// Our own copy of the graph and of the solver state. The edge list is kept in
	// load order; the distance and predecessor arrays survive between runs, but only
	// entries marked reached in the current run are ever looked at.
	logic [VW-1:0]        edge_tail [MAX_EDGES];
	logic [VW-1:0]        edge_head [MAX_EDGES];
	logic signed [WW-1:0] edge_wt   [MAX_EDGES];
	int                   edge_count;
	logic                 dropped_flag;
	int                   active_vertices;
	logic signed [DW-1:0] best_dist [MAX_VERTICES];
	logic                 reached_mark [MAX_VERTICES];
	logic [VW-1:0]        best_pred [MAX_VERTICES];

	// Vertex results still owed by the block, oldest first.
	vertex_result_t expected_vertices[$];

	int fail_count;
	int sender_idle_pct;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop in case the block hangs or never finishes a run.
	initial begin
		#(TIMEOUT_NS);
		$display("Some tests failed");
		$finish;
	end

	// Clamp a wide sum to the signed 32-bit range, as the block does on every
	// relaxation.
	function automatic logic signed [DW-1:0] clamp_sum(input logic signed [DW-1:0] a,
			input logic signed [WW-1:0] b);
		longint wide;
		wide = longint'(a) + longint'(b);
		if (wide > longint'(32'sh7fffffff)) begin
			return 32'sh7fffffff;
		end
		if (wide < -longint'(64'sd2147483648)) begin
			return 32'sh80000000;
		end
		return wide[DW-1:0];
	endfunction

	// Single-source run: repeated relaxation passes, tails visited in ascending
	// order and the edges of one tail in load order, stopping after a pass that
	// changes nothing or after vertex count minus one passes. Then one result per
	// vertex in use is queued.
	function automatic void solve_from(input logic [VW-1:0] src);
		int pass;
		int t;
		int e;
		int h;
		logic changed;
		logic signed [DW-1:0] cand;
		vertex_result_t r;
		for (int v = 0; v < MAX_VERTICES; v++) begin
			reached_mark[v] = 1'b0;
		end
		if (int'(src) < active_vertices) begin
			best_dist[src]    = '0;
			best_pred[src]    = '0;
			reached_mark[src] = 1'b1;
			for (pass = 0; pass + 1 < active_vertices; pass++) begin
				changed = 1'b0;
				for (t = 0; t < active_vertices; t++) begin
					if (!reached_mark[t]) begin
						continue;
					end
					for (e = 0; e < edge_count; e++) begin
						if (int'(edge_tail[e]) != t) begin
							continue;
						end
						h = int'(edge_head[e]);
						// A head outside the vertices in use is never relaxed.
						if (h >= active_vertices) begin
							continue;
						end
						cand = clamp_sum(best_dist[t], edge_wt[e]);
						if (!reached_mark[h] || cand < best_dist[h]) begin
							best_dist[h]    = cand;
							best_pred[h]    = VW'(t);
							reached_mark[h] = 1'b1;
							changed         = 1'b1;
						end
					end
				end
				if (!changed) begin
					break;
				end
			end
		end
		for (int v = 0; v < active_vertices; v++) begin
			r.vertex   = VW'(v);
			r.reached  = reached_mark[v];
			r.path_len = reached_mark[v] ? best_dist[v] : '0;
			r.via      = reached_mark[v] ? best_pred[v] : '0;
			r.dropped  = dropped_flag;
			r.is_last  = (v + 1 == active_vertices);
			expected_vertices.push_back(r);
		end
	endfunction

	// State update for one accepted request.
	function automatic void apply_request(input op_t op, input logic [VW-1:0] tail,
			input logic [VW-1:0] head, input logic signed [WW-1:0] wt,
			input logic [VW-1:0] src);
		case (op)
			OP_CLEAR: begin
				edge_count   = 0;
				dropped_flag = 1'b0;
			end
			OP_ADD: begin
				if (edge_count >= MAX_EDGES) begin
					dropped_flag = 1'b1;
				end else begin
					edge_tail[edge_count] = tail;
					edge_head[edge_count] = head;
					edge_wt[edge_count]   = wt;
					edge_count++;
				end
			end
			OP_RUN: solve_from(src);
			default: ;
		endcase
	endfunction

	// Drive one request and wait until the block takes it. Start is left high
	// on return so that a following request can go out back to back; every caller
	// either sends again or lowers start in the same time step.
	task automatic send_request(input op_t op, input logic [VW-1:0] tail,
			input logic [VW-1:0] head, input logic signed [WW-1:0] wt,
			input logic [VW-1:0] src);
		int gap = 0;
		while ($urandom_range(99) < sender_idle_pct && gap < 20) begin
			gap++;
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start         <= 1'b1;
		operation     <= op;
		from_vertex   <= tail;
		to_vertex     <= head;
		edge_weight   <= wt;
		source_vertex <= src;
		do @(posedge clk); while (busy);
		apply_request(op, tail, head, wt, src);
	endtask

	// Stop sending, let every owed result arrive, then give a request that
	// produces no result time to finish.
	task automatic drain_results();
		start <= 1'b0;
		while (expected_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	// The vertex count register is written only with the block idle. Out of range
	// values are clamped by the block: zero acts as one, above the maximum as the
	// maximum.
	task automatic set_vertex_count(input logic [NW-1:0] value);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (value == 0) begin
			active_vertices = 1;
		end else if (int'(value) > MAX_VERTICES) begin
			active_vertices = MAX_VERTICES;
		end else begin
			active_vertices = int'(value);
		end
	endtask

	function automatic logic [VW-1:0] any_vertex();
		return VW'($urandom);
	endfunction

	// Mostly a vertex in use, now and then any vertex at all.
	function automatic logic [VW-1:0] graph_vertex();
		if ($urandom_range(9) == 0) begin
			return any_vertex();
		end
		return VW'($urandom_range(active_vertices - 1));
	endfunction

	// Mostly small positive weights so that runs settle, with some negative ones
	// that may close negative cycles and some over the whole 16-bit range.
	function automatic logic signed [WW-1:0] graph_weight();
		case ($urandom_range(9))
			0: return WW'($urandom);
			1: return -WW'($urandom_range(20));
			default: return WW'($urandom_range(100));
		endcase
	endfunction

	task automatic check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	// Every result strobe is matched against the oldest owed result. The block
	// updates its outputs on the clock edge, so sampling here sees the values of
	// the cycle that this edge closes.
	always @(posedge clk) begin
		vertex_result_t exp_r;
		if (result_valid === 1'b1) begin
			if (expected_vertices.size() == 0) begin
				$error("result for vertex %0d with no request pending", vertex_index);
				fail_count++;
			end else begin
				exp_r = expected_vertices.pop_front();
				check_field("vertex_index", exp_r.vertex, vertex_index);
				check_field("distance", exp_r.path_len, distance);
				check_field("reachable", exp_r.reached, reachable);
				check_field("predecessor", exp_r.via, predecessor);
				check_field("edges_dropped", exp_r.dropped, edges_dropped);
				check_field("last", exp_r.is_last, last);
			end
		end
	end

	// Straight after reset the list is empty and all 64 vertices are in use.
	// Runs from both ends of the source range.
	task automatic test_reset_state();
		sender_idle_pct = 0;
		send_request(OP_RUN, '0, '0, '0, '0);
		send_request(OP_RUN, '1, '1, '1, '1);
		drain_results();
	endtask

	// The register at its limits and beyond them. A source past the last vertex in
	// use reaches nothing but still yields a full set of unreachable results.
	task automatic test_register_limits();
		sender_idle_pct = 0;
		set_vertex_count(NW'(0));
		send_request(OP_RUN, '0, '0, '0, VW'(0));
		send_request(OP_RUN, '0, '0, '0, VW'(1));
		set_vertex_count(NW'(127));
		send_request(OP_RUN, '0, '0, '0, VW'(5));
		set_vertex_count(NW'(MAX_VERTICES + 1));
		send_request(OP_RUN, '0, '0, '0, VW'(63));
		set_vertex_count(NW'(1));
		send_request(OP_RUN, '0, '0, '0, VW'(0));
		drain_results();
	endtask

	// A hand-built six-vertex graph: a shorter path found through a later tail,
	// a parallel edge that loses, both weight extremes, edges touching a vertex
	// outside the ones in use, an unreachable vertex and an ignored operation.
	task automatic test_small_graph();
		sender_idle_pct = 38;
		set_vertex_count(NW'(6));
		send_request(OP_CLEAR, any_vertex(), any_vertex(), WW'($urandom), any_vertex());
		send_request(OP_ADD, VW'(0), VW'(1), 16'sd4, any_vertex());
		send_request(OP_ADD, VW'(0), VW'(2), 16'sd1, any_vertex());
		send_request(OP_ADD, VW'(2), VW'(1), 16'sd1, any_vertex());
		send_request(OP_ADD, VW'(1), VW'(3), -16'sd32768, any_vertex());
		send_request(OP_ADD, VW'(3), VW'(4), 16'sd32767, any_vertex());
		send_request(OP_ADD, VW'(2), VW'(63), 16'sd7, any_vertex());
		send_request(OP_ADD, VW'(63), VW'(0), 16'sd5, any_vertex());
		send_request(OP_NONE, '1, '1, '1, '1);
		send_request(OP_ADD, VW'(1), VW'(3), 16'sd100, any_vertex());
		send_request(OP_RUN, any_vertex(), any_vertex(), WW'($urandom), VW'(0));
		send_request(OP_RUN, any_vertex(), any_vertex(), WW'($urandom), VW'(63));
		send_request(OP_RUN, any_vertex(), any_vertex(), WW'($urandom), VW'(5));
		send_request(OP_RUN, any_vertex(), any_vertex(), WW'($urandom), VW'(3));
		drain_results();
	endtask

	// A ring through all 64 vertices with the most negative weight on every
	// edge. The distances keep falling on every pass, so the run goes the full
	// number of passes without settling.
	task automatic test_negative_ring();
		sender_idle_pct = 0;
		set_vertex_count(NW'(MAX_VERTICES));
		send_request(OP_CLEAR, '0, '0, '0, '0);
		for (int v = 0; v < MAX_VERTICES; v++) begin
			send_request(OP_ADD, VW'(v), VW'((v + 1) % MAX_VERTICES), -16'sd32768, '0);
		end
		send_request(OP_RUN, '0, '0, '0, VW'(0));
		send_request(OP_RUN, '0, '0, '0, VW'(10));
		drain_results();
	endtask

	// Fill the edge list to capacity with edges on an unused vertex, then add
	// one more that must be dropped. The dropped flag shows on every result until
	// the next clear.
	task automatic test_edge_overflow();
		sender_idle_pct = 0;
		set_vertex_count(NW'(4));
		send_request(OP_CLEAR, '0, '0, '0, '0);
		send_request(OP_ADD, VW'(0), VW'(1), -16'sd5, '0);
		send_request(OP_ADD, VW'(1), VW'(2), 16'sd3, '0);
		for (int i = 2; i < MAX_EDGES; i++) begin
			send_request(OP_ADD, VW'(63), VW'(63), WW'($urandom), '0);
		end
		send_request(OP_ADD, VW'(2), VW'(3), 16'sd1, '0);
		send_request(OP_RUN, '0, '0, '0, VW'(0));
		send_request(OP_ADD, VW'(0), VW'(3), 16'sd1, '0);
		send_request(OP_RUN, '0, '0, '0, VW'(1));
		send_request(OP_CLEAR, '0, '0, '0, '0);
		send_request(OP_RUN, '0, '0, '0, VW'(0));
		drain_results();
	endtask

	// Random graphs: mostly a clear, a batch of edges on the vertices in use and
	// one or two runs; now and then a burst of arbitrary requests. The vertex
	// count changes between sequences, mostly to small values so runs stay short.
	task automatic test_random(input int budget, input int idle_pct);
		int sent;
		int n_edges;
		int n_runs;
		int n_noise;
		op_t op;
		sent = 0;
		sender_idle_pct = idle_pct;
		while (sent < budget) begin
			case ($urandom_range(9))
				0: set_vertex_count(NW'($urandom_range(127)));
				1, 2: set_vertex_count(NW'($urandom_range(2, 10)));
				3: set_vertex_count(NW'(MAX_VERTICES));
				default: ;
			endcase
			if ($urandom_range(9) < 8) begin
				if ($urandom_range(9) != 0) begin
					send_request(OP_CLEAR, any_vertex(), any_vertex(), WW'($urandom),
						any_vertex());
					sent++;
				end
				n_edges = $urandom_range(1, 16);
				repeat (n_edges) begin
					send_request(OP_ADD, graph_vertex(), graph_vertex(), graph_weight(),
						any_vertex());
					sent++;
				end
				n_runs = $urandom_range(1, 2);
				repeat (n_runs) begin
					send_request(OP_RUN, any_vertex(), any_vertex(), WW'($urandom),
						graph_vertex());
					sent++;
				end
			end else begin
				n_noise = $urandom_range(1, 6);
				repeat (n_noise) begin
					op = op_t'($urandom_range(3));
					send_request(op, any_vertex(), any_vertex(), WW'($urandom),
						any_vertex());
					if (op != OP_NONE) begin
						sent++;
					end
				end
			end
			// Sometimes hold the next request back until the block has caught up.
			if ($urandom_range(7) == 0) begin
				drain_results();
			end
		end
		drain_results();
	endtask

	initial begin
		fail_count      = 0;
		sender_idle_pct = 0;
		edge_count      = 0;
		dropped_flag    = 1'b0;
		active_vertices = MAX_VERTICES;
		for (int v = 0; v < MAX_VERTICES; v++) begin
			reached_mark[v] = 1'b0;
		end

		arst_n        <= 1'b0;
		cfg_wen       <= 1'b0;
		cfg_wdata     <= '0;
		start         <= 1'b0;
		operation     <= OP_CLEAR;
		from_vertex   <= '0;
		to_vertex     <= '0;
		edge_weight   <= '0;
		source_vertex <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_register_limits();
		test_small_graph();
		test_negative_ring();
		test_edge_overflow();
		test_random(100, 0);
		test_random(105, 74);
		test_random(105, 38);

		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
